### sv/lobt_pkg.sv
// Package for the limit order book table: operation codes, widths of the order fields
// and the structs that run along the row of order cells.
// No dependencies.
`timescale 1ns / 1ps
package lobt_pkg;

   localparam int IdBits = 32;
   localparam int PriceBits = 16;
   localparam int QtyBits = 32;
   localparam int CountBits = 7;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic [IdBits-1:0] order_id;
      logic side;
      logic [PriceBits-1:0] price;
      logic qty_nz;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic found;
      logic claimed;
      logic have_bid;
      logic [PriceBits-1:0] bid;
      logic have_ask;
      logic [PriceBits-1:0] ask;
   } tok_type;

   typedef struct packed {
      logic strobe;
      logic commit;
   } fin_type;

endpackage

### sv/lobt_cell.sv
// One order slot of the book: holds an order and passes the sweep token to its neighbor.
// Depends on lobt_pkg.
`timescale 1ns / 1ps
module lobt_cell import lobt_pkg::*; #(
   parameter int CntW = 7
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  fin_type         fin,
   input  tok_type         tok_in,
   input  logic [CntW-1:0] cnt_in,
   output tok_type         tok_out,
   output logic [CntW-1:0] cnt_out
);

   logic valid_ff;
   logic pending_ff;
   logic [IdBits-1:0] id_ff;
   logic side_ff;
   logic [PriceBits-1:0] price_ff;
   tok_type tok_ff;
   tok_type tok_in_nxt;
   logic [CntW-1:0] cnt_ff;
   logic hit;
   logic keep;
   logic take;

   always_comb begin
      hit = valid_ff && (id_ff == cmd.order_id);
      keep = valid_ff && (cmd.mode != MODE_CLEAR) && !((cmd.mode == MODE_CANCEL) && hit);
      take = (cmd.mode == MODE_ADD) && cmd.qty_nz && !valid_ff && !tok_in.claimed;
      tok_in_nxt = tok_in;
      tok_in_nxt.found = tok_in.found || hit;
      tok_in_nxt.claimed = tok_in.claimed || take;
      if (keep) begin
         if (!side_ff) begin
            if (!tok_in.have_bid || (price_ff > tok_in.bid)) begin
               tok_in_nxt.have_bid = 1'b1;
               tok_in_nxt.bid = price_ff;
            end
         end else begin
            if (!tok_in.have_ask || (price_ff < tok_in.ask)) begin
               tok_in_nxt.have_ask = 1'b1;
               tok_in_nxt.ask = price_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pending_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nxt;
         if (tok_in.active) begin
            if (take) begin
               pending_ff <= 1'b1;
            end
            if ((cmd.mode == MODE_CLEAR) || ((cmd.mode == MODE_CANCEL) && hit)) begin
               valid_ff <= 1'b0;
            end
         end
         if (fin.strobe) begin
            pending_ff <= 1'b0;
            if (fin.commit && pending_ff) begin
               valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in + CntW'(keep);
      if (tok_in.active && take) begin
         id_ff <= cmd.order_id;
         side_ff <= cmd.side;
         price_ff <= cmd.price;
      end
   end

   assign tok_out = tok_ff;
   assign cnt_out = cnt_ff;

endmodule

### sv/limit_order_book_table_top.sv
// Each accepted item gives one registered result on the rsp port. A new item is taken
// only in the idle state, once the previous item has finished; a token walks the row of
// order cells one cell per cycle, matching the identifier and reducing best prices and count.
// A waiting result does not block the next item; it only holds that item's finish.
// Reset clears all slot valid bits and control state at once; there is no clearing pass.
`timescale 1ns / 1ps
module limit_order_book_table_top import lobt_pkg::*; #(
   parameter int ORDER_SLOTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [IdBits-1:0]    req_order_id,
   input  logic                 req_side,
   input  logic [PriceBits-1:0] req_price,
   input  logic [QtyBits-1:0]   req_quantity,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_accepted,
   output logic                 rsp_bid_valid,
   output logic [PriceBits-1:0] rsp_best_bid_price,
   output logic                 rsp_ask_valid,
   output logic [PriceBits-1:0] rsp_best_ask_price,
   output logic                 rsp_mid_valid,
   output logic [PriceBits-1:0] rsp_mid_value,
   output logic [CountBits-1:0] rsp_resting_count
);

   localparam int CntW = $clog2(ORDER_SLOTS + 1);
   localparam int CntXW = (CntW > CountBits) ? CntW : CountBits;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   cmd_type cmd_ff;
   logic start_ff;
   tok_type fin_tok_ff;
   logic [CntW-1:0] fin_cnt_ff;
   fin_type fin;

   tok_type tok_chain [0:ORDER_SLOTS];
   logic [CntW-1:0] cnt_chain [0:ORDER_SLOTS];

   logic rsp_valid_ff;
   logic rsp_accepted_ff;
   logic rsp_bid_valid_ff;
   logic [PriceBits-1:0] rsp_bid_ff;
   logic rsp_ask_valid_ff;
   logic [PriceBits-1:0] rsp_ask_ff;
   logic rsp_mid_valid_ff;
   logic [PriceBits-1:0] rsp_mid_ff;
   logic [CntXW-1:0] rsp_cnt_ff;

   logic accept;
   logic rsp_free;
   logic add_ok;
   logic acc_in;
   logic have_bid_in;
   logic have_ask_in;
   logic [PriceBits-1:0] bid_in;
   logic [PriceBits-1:0] ask_in;
   logic [PriceBits:0] sum_in;
   logic [CntW-1:0] cnt_in;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign fin.strobe = (state_ff == ST_FINISH) && rsp_free;
   assign fin.commit = add_ok;

   always_comb begin
      tok_chain[0] = '0;
      tok_chain[0].active = start_ff;
      cnt_chain[0] = '0;
   end

   for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
      lobt_cell #(
         .CntW(CntW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd_ff),
         .fin    (fin),
         .tok_in (tok_chain[i]),
         .cnt_in (cnt_chain[i]),
         .tok_out(tok_chain[i+1]),
         .cnt_out(cnt_chain[i+1])
      );
   end

   always_comb begin
      add_ok = (cmd_ff.mode == MODE_ADD) && cmd_ff.qty_nz && !fin_tok_ff.found
               && fin_tok_ff.claimed;
      acc_in = add_ok || ((cmd_ff.mode == MODE_CANCEL) && fin_tok_ff.found)
               || (cmd_ff.mode == MODE_CLEAR);
      have_bid_in = fin_tok_ff.have_bid;
      bid_in = fin_tok_ff.bid;
      have_ask_in = fin_tok_ff.have_ask;
      ask_in = fin_tok_ff.ask;
      if (add_ok) begin
         if (!cmd_ff.side) begin
            if (!have_bid_in || (cmd_ff.price > bid_in)) begin
               bid_in = cmd_ff.price;
            end
            have_bid_in = 1'b1;
         end else begin
            if (!have_ask_in || (cmd_ff.price < ask_in)) begin
               ask_in = cmd_ff.price;
            end
            have_ask_in = 1'b1;
         end
      end
      sum_in = {1'b0, bid_in} + {1'b0, ask_in};
      cnt_in = fin_cnt_ff + CntW'(add_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= accept;
         if (fin.strobe) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               if (tok_chain[ORDER_SLOTS].active) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff.mode <= mode_type'(req_mode);
         cmd_ff.order_id <= req_order_id;
         cmd_ff.side <= req_side;
         cmd_ff.price <= req_price;
         cmd_ff.qty_nz <= |req_quantity;
      end
      if ((state_ff == ST_SWEEP) && tok_chain[ORDER_SLOTS].active) begin
         fin_tok_ff <= tok_chain[ORDER_SLOTS];
         fin_cnt_ff <= cnt_chain[ORDER_SLOTS];
      end
      if (fin.strobe) begin
         rsp_accepted_ff <= acc_in;
         rsp_bid_valid_ff <= have_bid_in;
         rsp_bid_ff <= bid_in;
         rsp_ask_valid_ff <= have_ask_in;
         rsp_ask_ff <= ask_in;
         rsp_mid_valid_ff <= have_bid_in && have_ask_in;
         rsp_mid_ff <= (have_bid_in && have_ask_in) ? sum_in[PriceBits:1] : '0;
         rsp_cnt_ff <= CntXW'(cnt_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_bid_valid = rsp_bid_valid_ff;
   assign rsp_best_bid_price = rsp_bid_ff;
   assign rsp_ask_valid = rsp_ask_valid_ff;
   assign rsp_best_ask_price = rsp_ask_ff;
   assign rsp_mid_valid = rsp_mid_valid_ff;
   assign rsp_mid_value = rsp_mid_ff;
   assign rsp_resting_count = rsp_cnt_ff[CountBits-1:0];

   a_token_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      tok_chain[ORDER_SLOTS].active |-> (state_ff == ST_SWEEP))
      else $error("sweep token reached the end of the row outside a sweep");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cnt_ff <= CntXW'(ORDER_SLOTS)))
      else $error("resting order count exceeds the table size");

   a_finish_gives_item: assert property (@(posedge clock) disable iff (reset)
      fin.strobe |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item was not presented on the result port");

   a_start_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (start_ff && (state_ff == ST_SWEEP)))
      else $error("accepted item did not start a sweep");

endmodule

### tb/tb_limit_order_book_table_top.sv
// Self-checking testbench for limit_order_book_table_top: adds, cancels, clears and no-ops
// are applied to the order table and each result is checked against a local book model.
// Depends on lobt_pkg and limit_order_book_table_top.
`timescale 1ns / 1ps
module tb_limit_order_book_table_top;
   import lobt_pkg::*;

   localparam int SLOTS = 64;
   localparam int IDLE_LIMIT = 1500;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct {
      mode_type             mode;
      logic [IdBits-1:0]    order_id;
      logic                 side;
      logic [PriceBits-1:0] price;
      logic [QtyBits-1:0]   quantity;
      int                   gap;
      bit                   hold;
   } order_item_type;

   typedef struct packed {
      logic                 accepted;
      logic                 bid_valid;
      logic [PriceBits-1:0] bid_px;
      logic                 ask_valid;
      logic [PriceBits-1:0] ask_px;
      logic                 mid_valid;
      logic [PriceBits-1:0] mid;
      logic [CountBits-1:0] count;
   } book_quote_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_mode = MODE_NOP;
   logic [IdBits-1:0]    req_order_id = '0;
   logic                 req_side = 1'b0;
   logic [PriceBits-1:0] req_price = '0;
   logic [QtyBits-1:0]   req_quantity = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_accepted;
   logic                 rsp_bid_valid;
   logic [PriceBits-1:0] rsp_best_bid_price;
   logic                 rsp_ask_valid;
   logic [PriceBits-1:0] rsp_best_ask_price;
   logic                 rsp_mid_valid;
   logic [PriceBits-1:0] rsp_mid_value;
   logic [CountBits-1:0] rsp_resting_count;

   order_item_type order_queue[$];
   book_quote_type quote_fifo[$];
   book_quote_type got_quote;

   logic                 book_live[SLOTS];
   logic [IdBits-1:0]    book_id[SLOTS];
   logic                 book_side[SLOTS];
   logic [PriceBits-1:0] book_price[SLOTS];

   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int adds_taken = 0;
   int full_refused = 0;
   int dup_refused = 0;
   int zero_refused = 0;
   int cancels_hit = 0;
   int cancels_missed = 0;
   int clears = 0;
   int nops = 0;
   int peak_depth = 0;
   int idle_cycles = 0;
   int recv_wait = 0;
   bit recv_calm = 1'b0;
   bit send_calm = 1'b0;

   limit_order_book_table_top #(.ORDER_SLOTS(SLOTS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_order_id(req_order_id),
      .req_side(req_side),
      .req_price(req_price),
      .req_quantity(req_quantity),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted),
      .rsp_bid_valid(rsp_bid_valid),
      .rsp_best_bid_price(rsp_best_bid_price),
      .rsp_ask_valid(rsp_ask_valid),
      .rsp_best_ask_price(rsp_best_ask_price),
      .rsp_mid_valid(rsp_mid_valid),
      .rsp_mid_value(rsp_mid_value),
      .rsp_resting_count(rsp_resting_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic book_quote_type apply_order(mode_type op, logic [IdBits-1:0] id,
                                                  logic side, logic [PriceBits-1:0] price,
                                                  logic [QtyBits-1:0] qty);
      int hit;
      int free_slot;
      int depth;
      book_quote_type q;
      logic [PriceBits:0] sum;
      hit = -1;
      free_slot = -1;
      depth = 0;
      q = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && book_live[i] && book_id[i] == id) hit = i;
         if (free_slot < 0 && !book_live[i]) free_slot = i;
      end
      case (op)
         MODE_ADD: begin
            if (qty == '0) begin
               zero_refused++;
            end else if (hit >= 0) begin
               dup_refused++;
            end else if (free_slot < 0) begin
               full_refused++;
            end else begin
               book_live[free_slot] = 1'b1;
               book_id[free_slot] = id;
               book_side[free_slot] = side;
               book_price[free_slot] = price;
               q.accepted = 1'b1;
               adds_taken++;
            end
         end
         MODE_CANCEL: begin
            if (hit >= 0) begin
               book_live[hit] = 1'b0;
               q.accepted = 1'b1;
               cancels_hit++;
            end else begin
               cancels_missed++;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) book_live[i] = 1'b0;
            q.accepted = 1'b1;
            clears++;
         end
         default: nops++;
      endcase
      for (int i = 0; i < SLOTS; i++) begin
         if (book_live[i]) begin
            depth++;
            if (book_side[i] == 1'b0) begin
               if (!q.bid_valid || book_price[i] > q.bid_px) q.bid_px = book_price[i];
               q.bid_valid = 1'b1;
            end else begin
               if (!q.ask_valid || book_price[i] < q.ask_px) q.ask_px = book_price[i];
               q.ask_valid = 1'b1;
            end
         end
      end
      if (q.bid_valid && q.ask_valid) begin
         sum = {1'b0, q.bid_px} + {1'b0, q.ask_px};
         q.mid_valid = 1'b1;
         q.mid = sum[PriceBits:1];
      end
      q.count = depth[CountBits-1:0];
      if (depth > peak_depth) peak_depth = depth;
      return q;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] check failed on %s: got %0h, want %0h", $time, what, got, want);
      errors++;
   endtask

   task automatic check_quote(book_quote_type got, book_quote_type want);
      if (got.accepted !== want.accepted)
         report_mismatch("accepted", got.accepted, want.accepted);
      if (got.bid_valid !== want.bid_valid)
         report_mismatch("bid_valid", got.bid_valid, want.bid_valid);
      if (got.bid_px !== want.bid_px)
         report_mismatch("best_bid_price", got.bid_px, want.bid_px);
      if (got.ask_valid !== want.ask_valid)
         report_mismatch("ask_valid", got.ask_valid, want.ask_valid);
      if (got.ask_px !== want.ask_px)
         report_mismatch("best_ask_price", got.ask_px, want.ask_px);
      if (got.mid_valid !== want.mid_valid)
         report_mismatch("mid_valid", got.mid_valid, want.mid_valid);
      if (got.mid !== want.mid)
         report_mismatch("mid_value", got.mid, want.mid);
      if (got.count !== want.count)
         report_mismatch("resting_count", got.count, want.count);
   endtask

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_order(mode_type op, logic [IdBits-1:0] id, logic side,
                              logic [PriceBits-1:0] price, logic [QtyBits-1:0] qty,
                              bit hold);
      order_item_type item;
      if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      item.mode = op;
      item.order_id = id;
      item.side = side;
      item.price = price;
      item.quantity = qty;
      item.gap = send_calm ? 0 : draw_gap();
      item.hold = hold;
      order_queue.insert(order_queue.size(), item);
   endtask

   function automatic logic [QtyBits-1:0] live_qty();
      logic [QtyBits-1:0] q;
      q = $urandom;
      if (q == '0) q = 1;
      return q;
   endfunction

   function automatic logic [PriceBits-1:0] pick_price();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      if (r < 50) return 16'(16'h7FF0 + $urandom_range(0, 31));
      return 16'($urandom);
   endfunction

   // The sender holds an item back while its gap runs, and a held item also waits
   // until every outstanding result has come back.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (order_queue.size() != 0 && order_queue[0].gap > 0) begin
            order_queue[0].gap--;
            req_valid <= 1'b0;
         end else if (order_queue.size() != 0 &&
                      !(order_queue[0].hold && (quote_fifo.size() != 0 || req_valid))) begin
            req_mode <= order_queue[0].mode;
            req_order_id <= order_queue[0].order_id;
            req_side <= order_queue[0].side;
            req_price <= order_queue[0].price;
            req_quantity <= order_queue[0].quantity;
            req_valid <= 1'b1;
            void'(order_queue.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_quote = '{rsp_accepted, rsp_bid_valid, rsp_best_bid_price, rsp_ask_valid,
                          rsp_best_ask_price, rsp_mid_valid, rsp_mid_value, rsp_resting_count};
            if (quote_fifo.size() == 0)
               report_mismatch("unrequested result", got_quote, 0);
            else
               check_quote(got_quote, quote_fifo.pop_front());
            results_seen++;
         end
         if (req_valid && req_ready) begin
            quote_fifo.insert(quote_fifo.size(),
                              apply_order(mode_type'(req_mode), req_order_id, req_side,
                                          req_price, req_quantity));
            items_sent++;
         end
         if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!recv_calm && $urandom_range(0, 3) == 0) recv_wait = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("limit_order_book_table_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int queued;
      int r;
      logic [IdBits-1:0] id_base;
      logic [IdBits-1:0] fill_base;

      for (int i = 0; i < SLOTS; i++) begin
         book_live[i] = 1'b0;
         book_id[i] = '0;
         book_side[i] = 1'b0;
         book_price[i] = '0;
      end

      queue_order(MODE_CANCEL, 32'd5, 1'b0, 16'd0, 32'd0, 1'b0);
      queue_order(MODE_NOP, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);
      queue_order(MODE_CLEAR, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);
      queue_order(MODE_ADD, 32'h0000_0000, 1'b0, 16'h0000, 32'd1, 1'b0);
      queue_order(MODE_ADD, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_order(MODE_ADD, 32'h0000_0000, 1'b1, 16'd100, 32'd5, 1'b0);
      queue_order(MODE_ADD, 32'd7, 1'b0, 16'd1000, 32'd0, 1'b0);
      queue_order(MODE_ADD, 32'd7, 1'b0, 16'hFFFF, 32'd3, 1'b0);
      queue_order(MODE_ADD, 32'd8, 1'b1, 16'h0000, 32'd9, 1'b0);
      queue_order(MODE_CANCEL, 32'h0000_0000, 1'b0, 16'd0, 32'd0, 1'b0);
      queue_order(MODE_CANCEL, 32'h0000_0000, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_order(MODE_CANCEL, 32'd1, 1'b1, 16'h1234, 32'd0, 1'b0);
      queue_order(MODE_NOP, 32'hA5A5_5A5A, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_order(MODE_ADD, 32'h8000_0000, 1'b0, 16'h8000, 32'h8000_0000, 1'b0);
      queue_order(MODE_CANCEL, 32'd8, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_order(MODE_CLEAR, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_order(MODE_ADD, 32'h1234_5678, 1'b1, 16'h00FF, 32'd2, 1'b0);
      queue_order(MODE_ADD, 32'hFFFF_FFFF, 1'b0, 16'h00FE, 32'd4, 1'b0);
      queue_order(MODE_CANCEL, 32'h1234_5678, 1'b0, 16'd0, 32'd0, 1'b0);
      queue_order(MODE_CLEAR, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);

      queued = 0;
      id_base = $urandom;
      while (queued < RANDOM_ITEMS) begin
         if (queued % 300 == 0) begin
            // Fill the table past its capacity, then free one slot and refill it.
            fill_base = $urandom;
            queue_order(MODE_CLEAR, $urandom, 1'($urandom), 16'($urandom), $urandom, 1'b1);
            for (int k = 0; k < SLOTS + 2; k++)
               queue_order(MODE_ADD, fill_base + k, 1'($urandom), pick_price(), live_qty(),
                           1'b0);
            queue_order(MODE_CANCEL, fill_base + $urandom_range(0, SLOTS - 1), 1'($urandom),
                        16'($urandom), $urandom, 1'b0);
            queue_order(MODE_ADD, fill_base + SLOTS + 5, 1'($urandom), pick_price(),
                        live_qty(), 1'b0);
            queue_order(MODE_ADD, fill_base + SLOTS + 6, 1'($urandom), pick_price(),
                        live_qty(), 1'b0);
            queue_order(MODE_ADD, fill_base + 3, 1'($urandom), pick_price(), live_qty(),
                        1'b0);
            queued += SLOTS + 7;
            id_base = fill_base;
         end
         if ($urandom_range(0, 99) < 4) begin
            r = $urandom_range(0, 3);
            id_base = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFD0 : 32'($urandom);
         end
         r = $urandom_range(0, 99);
         if (r < 55)
            queue_order(MODE_ADD, id_base + $urandom_range(0, 47), 1'($urandom), pick_price(),
                        ($urandom_range(0, 11) == 0) ? 32'd0 : live_qty(), 1'b0);
         else if (r < 90)
            queue_order(MODE_CANCEL, id_base + $urandom_range(0, 47), 1'($urandom),
                        16'($urandom), $urandom, 1'b0);
         else if (r < 93)
            queue_order(MODE_CLEAR, $urandom, 1'($urandom), 16'($urandom), $urandom, 1'b0);
         else
            queue_order(MODE_NOP, $urandom, 1'($urandom), 16'($urandom), $urandom, 1'b0);
         queued++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (order_queue.size() != 0 || req_valid) @(posedge clock);
      while (quote_fifo.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);

      $display("%0d items, %0d results; %0d adds taken; refused %0d full, %0d dup, %0d zero",
               items_sent, results_seen, adds_taken, full_refused, dup_refused, zero_refused);
      $display("%0d cancels (%0d unknown), %0d clears, %0d no-ops, deepest book %0d orders",
               cancels_hit + cancels_missed, cancels_missed, clears, nops, peak_depth);
      if (errors == 0 && quote_fifo.size() == 0) begin
         $display("limit_order_book_table_top: match");
      end else begin
         $display("limit_order_book_table_top: mismatch");
      end
      $finish;
   end

endmodule
